### sv/qpt_pkg.sv
// Shared types, constants and the x4 transition decode for the quadrature position tracker.
package qpt_pkg;

	localparam int unsigned CPR_W = 16;
	localparam int unsigned POS_W = 32;
	localparam int unsigned REV_W = 31;
	localparam logic [CPR_W-1:0] CPR_RESET = 16'd1024;
	localparam logic [1:0] AB_RESET = 2'b11;

	typedef enum logic [1:0] {
		STEP_NONE,
		STEP_UP,
		STEP_DOWN
	} step_t;

	typedef struct packed {
		logic busy;
		logic done;
	} qpt_div_stat_t;

	function automatic step_t step_decode(input logic [3:0] idx);
		step_t s;
		case (idx)
			4'b0001, 4'b0111, 4'b1000, 4'b1110: s = STEP_DOWN;
			4'b0010, 4'b0100, 4'b1011, 4'b1101: s = STEP_UP;
			default: s = STEP_NONE;
		endcase
		return s;
	endfunction

endpackage

### sv/qpt_step.sv
// Transition decode and saturating position counter.
module qpt_step #(
	parameter int unsigned COUNT_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic                          chan_a,
	input  logic                          chan_b,
	output logic signed [COUNT_WIDTH-1:0] count_q
);
	import qpt_pkg::*;

	localparam logic signed [COUNT_WIDTH-1:0] LIM_POS = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
	localparam logic signed [COUNT_WIDTH-1:0] LIM_NEG = -LIM_POS;
	localparam logic signed [COUNT_WIDTH-1:0] ONE = COUNT_WIDTH'(1);

	logic [1:0] prev_ab_q;
	step_t step;

	assign step = step_decode({prev_ab_q, chan_a, chan_b});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_ab_q <= AB_RESET;
			count_q <= '0;
		end else if (accept) begin
			prev_ab_q <= {chan_a, chan_b};
			case (step)
				STEP_UP: begin
					if (count_q != LIM_POS) count_q <= count_q + ONE;
				end
				STEP_DOWN: begin
					if (count_q != LIM_NEG) count_q <= count_q - ONE;
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

endmodule

### sv/qpt_divider.sv
// Restoring divider that produces one quotient bit per cycle.
module qpt_divider #(
	parameter int unsigned MAG_W = 31
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [MAG_W-1:0]          dividend,
	input  logic [qpt_pkg::CPR_W-1:0] divisor,
	output logic [MAG_W-1:0]          quotient,
	output logic [qpt_pkg::CPR_W-1:0] remainder,
	output qpt_pkg::qpt_div_stat_t    stat
);
	import qpt_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAG_W + 1);

	logic [MAG_W-1:0] dq_q;
	logic [CPR_W-1:0] rem_q;
	logic [CPR_W-1:0] div_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [CPR_W+1:0] diff;
	logic             borrow;

	assign diff = {1'b0, rem_q, dq_q[MAG_W-1]} - {2'b00, div_q};
	assign borrow = diff[CPR_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(MAG_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			if (!borrow) rem_q <= diff[CPR_W-1:0];
			else rem_q <= {rem_q[CPR_W-2:0], dq_q[MAG_W-1]};
			dq_q <= {dq_q[MAG_W-2:0], ~borrow};
		end
	end

	assign quotient = dq_q;
	assign remainder = rem_q;
	assign stat = '{busy: busy_q, done: done_q};

endmodule

### sv/quadrature_position_tracker.sv
// Top level of the x4 quadrature position tracker with revolution split.
//
//   Channel  Direction  Handshake                  Payload
//   in       sink       in_valid / in_ready        chan_a, chan_b
//   out      source     out_valid / out_ready      position_count, is_negative,
//                                                  whole_revs, rev_position
//   cfg      sink       cfg_wr_en (no wait)        cfg_wr_data (counts_per_rev)
//
// After acceptance an item passes the load state, the bit-serial divider loop and the
// finish state before its result is registered.
// The block accepts a new item the cycle after the result enters the output register,
// so it takes no new item while one is in flight; a result waiting in the output
// register does not block acceptance, but a finished division waits for the register.
// Reset clears the count to zero, the previous channel pair to both high and
// counts_per_rev to 1024; no clearing pass is needed.
module quadrature_position_tracker #(
	parameter int unsigned COUNT_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [qpt_pkg::CPR_W-1:0]        cfg_wr_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             chan_a,
	input  logic                             chan_b,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [qpt_pkg::POS_W-1:0] position_count,
	output logic                             is_negative,
	output logic [qpt_pkg::REV_W-1:0]        whole_revs,
	output logic [qpt_pkg::CPR_W-1:0]        rev_position
);
	import qpt_pkg::*;

	localparam int unsigned MAG_W = COUNT_WIDTH - 1;
	localparam int unsigned QX_W = (MAG_W > REV_W) ? MAG_W : REV_W;
	localparam int unsigned PX_W = (COUNT_WIDTH > POS_W) ? COUNT_WIDTH : POS_W;
	localparam int unsigned MX_W = (MAG_W > CPR_W) ? MAG_W : CPR_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t state_q;
	logic [CPR_W-1:0] cpr_q;
	logic out_valid_q;
	logic signed [POS_W-1:0] pos_q;
	logic neg_q;
	logic [REV_W-1:0] revs_q;
	logic [CPR_W-1:0] rpos_q;

	logic in_accept;
	logic signed [COUNT_WIDTH-1:0] count;
	logic signed [COUNT_WIDTH-1:0] count_abs;
	logic [MAG_W-1:0] mag;
	logic [MAG_W-1:0] quot;
	logic [CPR_W-1:0] rem;
	qpt_div_stat_t div_stat;
	logic slot_free;
	logic [QX_W-1:0] quot_ext;
	logic signed [PX_W-1:0] pos_ext;
	logic [MX_W-1:0] mag_ext;

	assign in_ready = (state_q == ST_IDLE);
	assign in_accept = in_valid && in_ready;

	qpt_step #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_step (
		.clk(clk),
		.arst_n(arst_n),
		.accept(in_accept),
		.chan_a(chan_a),
		.chan_b(chan_b),
		.count_q(count)
	);

	assign count_abs = count[COUNT_WIDTH-1] ? -count : count;
	assign mag = count_abs[MAG_W-1:0];

	qpt_divider #(
		.MAG_W(MAG_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(state_q == ST_LOAD),
		.dividend(mag),
		.divisor(cpr_q),
		.quotient(quot),
		.remainder(rem),
		.stat(div_stat)
	);

	assign quot_ext = QX_W'(quot);
	assign pos_ext = PX_W'(count);
	assign mag_ext = MX_W'(mag);
	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpr_q <= CPR_RESET;
		end else if (cfg_wr_en) begin
			cpr_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_stat.done) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (slot_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && slot_free) begin
			pos_q <= pos_ext[POS_W-1:0];
			neg_q <= count[COUNT_WIDTH-1];
			if (cpr_q == '0) begin
				revs_q <= {REV_W{1'b1}};
				rpos_q <= mag_ext[CPR_W-1:0];
			end else begin
				revs_q <= quot_ext[REV_W-1:0];
				rpos_q <= rem;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign position_count = pos_q;
	assign is_negative = neg_q;
	assign whole_revs = revs_q;
	assign rev_position = rpos_q;

endmodule

### sv/qpt_checker.sv
// Port-level checker for the quadrature position tracker and its bind.
module qpt_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             cfg_wr_en,
	input logic [qpt_pkg::CPR_W-1:0]        cfg_wr_data,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             chan_a,
	input logic                             chan_b,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic signed [qpt_pkg::POS_W-1:0] position_count,
	input logic                             is_negative,
	input logic [qpt_pkg::REV_W-1:0]        whole_revs,
	input logic [qpt_pkg::CPR_W-1:0]        rev_position
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(position_count)
			&& $stable(whole_revs) && $stable(rev_position) && $stable(is_negative))
		else $error("Result item changed while stalled.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("Block ready again right after accepting an item.");

	a_sign_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> is_negative == position_count[qpt_pkg::POS_W-1])
		else $error("Negative flag disagrees with the count.");

	a_zero_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && position_count == '0 |-> rev_position == '0 && !is_negative)
		else $error("Zero count gave a nonzero position within the revolution.");

endmodule

bind quadrature_position_tracker qpt_checker u_qpt_checker (.*);

### tb/quadrature_position_tracker_tb.sv
// Self-checking testbench for the quadrature position tracker: walks, noise and revolution splits.
`timescale 1ns / 100ps

module quadrature_position_tracker_tb;

	localparam int TRACK_W = 32;

	class position_scoreboard;
		typedef struct {
			logic signed [31:0] count;
			logic               neg;
			logic [30:0]        revs;
			logic [15:0]        pos;
		} position_t;

		position_t   expected_positions[$];
		logic [1:0]  prev_ab;
		longint      count;
		longint      limit;
		logic [15:0] cpr;
		int          errors;

		function new(int width);
			prev_ab = qpt_pkg::AB_RESET;
			count = 0;
			limit = (longint'(1) <<< (width - 1)) - 1;
			cpr = qpt_pkg::CPR_RESET;
			errors = 0;
		endfunction

		// Rank of a channel pair along the counting-up Gray sequence 11, 01, 00, 10.
		static function int gray_rank(logic [1:0] ab);
			case (ab)
				2'b11: return 0;
				2'b01: return 1;
				2'b00: return 2;
				default: return 3;
			endcase
		endfunction

		static function logic [1:0] gray_ab(int rank);
			case (rank)
				0: return 2'b11;
				1: return 2'b01;
				2: return 2'b00;
				default: return 2'b10;
			endcase
		endfunction

		static function qpt_pkg::step_t transition(logic [1:0] from_ab, logic [1:0] to_ab);
			int d;
			d = (gray_rank(to_ab) - gray_rank(from_ab) + 4) % 4;
			if (d == 1)
				return qpt_pkg::STEP_UP;
			else if (d == 3)
				return qpt_pkg::STEP_DOWN;
			return qpt_pkg::STEP_NONE;
		endfunction

		function void note_input(logic [1:0] now_ab);
			qpt_pkg::step_t  dir;
			longint unsigned mag;
			position_t       e;
			dir = transition(prev_ab, now_ab);
			prev_ab = now_ab;
			if (dir == qpt_pkg::STEP_UP && count < limit)
				count++;
			else if (dir == qpt_pkg::STEP_DOWN && count > -limit)
				count--;
			mag = (count < 0) ? -count : count;
			e.count = count[31:0];
			e.neg = (count < 0);
			if (cpr == 16'd0) begin
				e.revs = '1;
				e.pos = mag[15:0];
			end else begin
				e.revs = 31'(mag / cpr);
				e.pos = 16'(mag % cpr);
			end
			expected_positions.push_back(e);
		endfunction

		task report(string what, logic signed [63:0] got, logic signed [63:0] want);
			errors++;
			if (errors <= 40)
				$display("MISMATCH %s: got %0d, expected %0d", what, got, want);
		endtask

		task check_result(logic signed [31:0] c, logic n, logic [30:0] r, logic [15:0] p);
			position_t e;
			if (expected_positions.size() == 0) begin
				report("unexpected result, position_count", c, 0);
				return;
			end
			e = expected_positions.pop_front();
			if (c !== e.count)
				report("position_count", c, e.count);
			if (n !== e.neg)
				report("is_negative", n, e.neg);
			if (r !== e.revs)
				report("whole_revs", r, e.revs);
			if (p !== e.pos)
				report("rev_position", p, e.pos);
		endtask
	endclass

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_wr_en;
	logic [qpt_pkg::CPR_W-1:0]        cfg_wr_data;
	logic                             in_valid;
	logic                             in_ready;
	logic                             chan_a;
	logic                             chan_b;
	logic                             out_valid;
	logic                             out_ready;
	logic signed [qpt_pkg::POS_W-1:0] position_count;
	logic                             is_negative;
	logic [qpt_pkg::REV_W-1:0]        whole_revs;
	logic [qpt_pkg::CPR_W-1:0]        rev_position;

	position_scoreboard tracker_sb;
	int                 stall_pct;
	logic [1:0]         cur_ab;
	int                 run_left;
	bit                 run_up;

	// Every ordered pair of channel states once, starting from the reset pair.
	logic [1:0] all_pairs [16] = '{2'd0, 2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd3, 2'd1,
		2'd1, 2'd2, 2'd1, 2'd3, 2'd2, 2'd2, 2'd3, 2'd3};

	quadrature_position_tracker #(
		.COUNT_WIDTH(TRACK_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.chan_a(chan_a),
		.chan_b(chan_b),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.position_count(position_count),
		.is_negative(is_negative),
		.whole_revs(whole_revs),
		.rev_position(rev_position)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker_sb.check_result(position_count, is_negative, whole_revs, rev_position);
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic logic [1:0] step_from(logic [1:0] ab, bit up);
		return position_scoreboard::gray_ab(
			(position_scoreboard::gray_rank(ab) + (up ? 1 : 3)) % 4);
	endfunction

	task automatic send_item(logic [1:0] ab, int idle_pct);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
		in_valid <= 1'b1;
		chan_a <= ab[1];
		chan_b <= ab[0];
		do
			@(posedge clk);
		while (!in_ready);
		tracker_sb.note_input(ab);
		cur_ab = ab;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (tracker_sb.expected_positions.size() != 0);
	endtask

	task automatic write_cpr(logic [15:0] value);
		wait_drained();
		repeat (40) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tracker_sb.cpr = value;
	endtask

	task automatic run_phase(int items, int idle, int stall, int up_pct, int noise_pct,
		int pause_every);
		logic [1:0] ab;
		stall_pct = stall;
		for (int k = 1; k <= items; k++) begin
			if (run_left == 0) begin
				run_left = $urandom_range(60, 1);
				run_up = ($urandom_range(99) < up_pct);
			end
			run_left--;
			if ($urandom_range(99) < noise_pct)
				ab = 2'($urandom_range(3));
			else
				ab = step_from(cur_ab, run_up);
			send_item(ab, idle);
			if (pause_every != 0 && k % pause_every == 0)
				wait_drained();
		end
	endtask

	initial begin
		#15_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		chan_a = 1'b1;
		chan_b = 1'b1;
		out_ready = 1'b0;
		stall_pct = 0;
		cur_ab = qpt_pkg::AB_RESET;
		run_left = 0;
		run_up = 1'b1;
		tracker_sb = new(TRACK_W);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// All sixteen transitions, then a walk below zero.
		foreach (all_pairs[i])
			send_item(all_pairs[i], 0);
		repeat (4) send_item(step_from(cur_ab, 1'b0), 0);
		// Small divisor so that negative counts land on exact multiples.
		write_cpr(16'd2);
		repeat (5) send_item(step_from(cur_ab, 1'b0), 0);

		write_cpr(qpt_pkg::CPR_RESET);
		run_phase(450, 0, 0, 100, 3, 100);
		write_cpr(16'hFFFF);
		run_phase(250, 75, 0, 50, 15, 0);
		write_cpr(16'd1);
		run_phase(300, 0, 75, 0, 5, 0);
		write_cpr(16'd0);
		run_phase(250, 30, 30, 0, 5, 0);
		write_cpr(16'd3);
		run_phase(150, 0, 0, 0, 5, 0);
		write_cpr(16'($urandom_range(100, 2)));
		run_phase(150, 30, 30, 50, 30, 0);

		wait_drained();
		repeat (40) @(posedge clk);
		if (tracker_sb.expected_positions.size() != 0)
			tracker_sb.report("results never produced, count",
				tracker_sb.expected_positions.size(), 0);
		if (tracker_sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### filelist.f
sv/qpt_pkg.sv
sv/qpt_step.sv
sv/qpt_divider.sv
sv/quadrature_position_tracker.sv
sv/qpt_checker.sv
tb/quadrature_position_tracker_tb.sv
